[src/ssc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types, constants and the Q1.14 trig table of the sector scan converter.
// ----------------------------------------------------------------------------
package ssc_pkg;

  localparam int ANGLE_TOP   = 180;
  localparam int MAX_FILL    = 63;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int DIV_STEPS   = 14;

  localparam logic [9:0] CENTER_X_RST = 10'd240;
  localparam logic [9:0] CENTER_Y_RST = 10'd28;

  // configuration register indexes
  localparam logic REG_CENTER_X = 1'b0;
  localparam logic REG_CENTER_Y = 1'b1;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef logic [14:0] trig_tab_t [0:90];

  // command word from front to back
  typedef struct packed {
    logic [7:0] ang;
    logic [7:0] prev_ang;
    logic [7:0] depth;
    logic [7:0] cur;
    logic [7:0] prev;
    logic [6:0] gap;
    logic       fill;
    logic       wide;
  } cmd_t;

  // nearest Q1.14 sine of deg in 0..90, Q30 Taylor series
  // term n is divided by (2n)(2n+1), signs alternate
  function automatic logic [14:0] sin_q14(input int unsigned deg);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned u;
    longint          sum;
    x    = (longint'(deg) * PI_Q30 + 64'd90) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd342;
    sum  = sum - longint'(term);
    if (sum < 0) sum = 0;
    u = (longint'(sum) + 64'd32768) >> 16;
    return u[14:0];
  endfunction

  function automatic trig_tab_t build_trig();
    trig_tab_t t;
    for (int k = 0; k <= 90; k++) t[k] = sin_q14(k);
    return t;
  endfunction

  localparam trig_tab_t TRIG_ROM = build_trig();

endpackage
`default_nettype wire

[src/sector_scan_converter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sector_scan_converter
// Ultrasound sector scan conversion of echo samples into RGB565 gray pixels.
// ----------------------------------------------------------------------------
// Path: an accepted sample waits in the front stage until queued; the back
//   end takes each command in turn through ST_GEO and ST_EMIT to the output
//   register, fill pixels first running the radix-2 divider (14 steps).
// Reset: control state cleared, center_x = 240, center_y = 28, no ray seen;
//   the previous-ray store is undefined until written.
module sector_scan_converter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_push,
  output logic                   in_full,
  input  wire logic [7:0]        in_ray_angle,
  input  wire logic [7:0]        in_depth_index,
  input  wire logic [7:0]        in_echo_value,
  input  wire logic              in_ray_end,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic signed [11:0]     out_pixel_x,
  output logic signed [11:0]     out_pixel_y,
  output logic [15:0]            out_pixel_color,
  output logic                   out_is_filled,
  output logic                   out_gap_too_wide,
  output logic                   out_last_pixel,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [9:0]        cfg_data
);

  logic [9:0]    center_x_r;
  logic [9:0]    center_y_r;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  ssc_pkg::cmd_t wr_cmd;
  ssc_pkg::cmd_t rd_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= ssc_pkg::CENTER_X_RST;
      center_y_r <= ssc_pkg::CENTER_Y_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssc_pkg::REG_CENTER_X: center_x_r <= cfg_data;
        ssc_pkg::REG_CENTER_Y: center_y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ssc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_ray_angle   (in_ray_angle),
    .in_depth_index (in_depth_index),
    .in_echo_value  (in_echo_value),
    .in_ray_end     (in_ray_end),
    .q_push         (q_push),
    .q_cmd          (wr_cmd),
    .q_full         (q_full)
  );

  ssc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (wr_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .rd_cmd (rd_cmd),
    .empty  (q_empty)
  );

  ssc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_cmd            (rd_cmd),
    .q_pop            (q_pop),
    .center_x         (center_x_r),
    .center_y         (center_y_r),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_pixel_color  (out_pixel_color),
    .out_is_filled    (out_is_filled),
    .out_gap_too_wide (out_gap_too_wide),
    .out_last_pixel   (out_last_pixel)
  );

endmodule
`default_nettype wire

[src/ssc_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module ssc_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ssc_pkg::cmd_t wr_cmd,
  output logic               full,
  input  wire logic          pop,
  output ssc_pkg::cmd_t      rd_cmd,
  output logic               empty
);

  ssc_pkg::cmd_t                  slot_r [0:ssc_pkg::QUEUE_DEPTH-1];
  logic [ssc_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [ssc_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [ssc_pkg::QPTR_W:0]       cnt_r;
  logic                           do_push;
  logic                           do_pop;

  assign full    = (cnt_r == (ssc_pkg::QPTR_W+1)'(ssc_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_cmd  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

[src/ssc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_front
// Accepts echo samples, keeps the previous ray and angle, classifies the gap.
// ----------------------------------------------------------------------------
module ssc_front (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_ray_angle,
  input  wire logic [7:0] in_depth_index,
  input  wire logic [7:0] in_echo_value,
  input  wire logic       in_ray_end,
  output logic            q_push,
  output ssc_pkg::cmd_t   q_cmd,
  input  wire logic       q_full
);

  logic [7:0]    ray_mem [0:255];
  logic [7:0]    prev_rd_r;
  ssc_pkg::cmd_t stage_r;
  logic          stage_vld_r;
  logic [7:0]    prev_ang_r;
  logic          prev_vld_r;
  logic          accept;
  logic [7:0]    ang_sat;
  logic [7:0]    gap;
  logic          jump;
  logic          wide;

  assign in_full = stage_vld_r;
  assign accept  = in_push && !stage_vld_r;
  assign ang_sat = (in_ray_angle > 8'(ssc_pkg::ANGLE_TOP)) ? 8'(ssc_pkg::ANGLE_TOP)
                                                           : in_ray_angle;
  assign jump    = prev_vld_r && ({1'b0, ang_sat} > {1'b0, prev_ang_r} + 9'd1);
  assign gap     = ang_sat - prev_ang_r;
  assign wide    = jump && ((gap - 8'd1) > 8'(ssc_pkg::MAX_FILL));

  // read-first: a fill sees the entry from before this sample
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_rd_r                <= ray_mem[in_depth_index];
      ray_mem[in_depth_index]  <= in_echo_value;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r.ang      <= ang_sat;
      stage_r.prev_ang <= prev_ang_r;
      stage_r.depth    <= in_depth_index;
      stage_r.cur      <= in_echo_value;
      stage_r.prev     <= '0;
      stage_r.gap      <= gap[6:0];
      stage_r.fill     <= jump && !wide;
      stage_r.wide     <= wide;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
      prev_ang_r  <= '0;
      prev_vld_r  <= 1'b0;
    end else begin
      if (accept) stage_vld_r <= 1'b1;
      else if (q_push) stage_vld_r <= 1'b0;
      if (accept && in_ray_end) begin
        prev_ang_r <= ang_sat;
        prev_vld_r <= 1'b1;
      end
    end
  end

  assign q_push = stage_vld_r && !q_full;

  always_comb begin
    q_cmd      = stage_r;
    q_cmd.prev = prev_rd_r;
  end

endmodule
`default_nettype wire

[src/ssc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ssc_back
// Runs commands: fill interpolation, polar to screen mapping, output word.
// ----------------------------------------------------------------------------
module ssc_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire ssc_pkg::cmd_t     q_cmd,
  output logic                   q_pop,
  input  wire logic [9:0]        center_x,
  input  wire logic [9:0]        center_y,
  output logic                   out_empty,
  input  wire logic              out_pop,
  output logic signed [11:0]     out_pixel_x,
  output logic signed [11:0]     out_pixel_y,
  output logic [15:0]            out_pixel_color,
  output logic                   out_is_filled,
  output logic                   out_gap_too_wide,
  output logic                   out_last_pixel
);

  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_DIV, ST_GEO, ST_EMIT} state_t;

  state_t        st_r;
  ssc_pkg::cmd_t cmd_r;
  logic [5:0]    k_r;
  logic [13:0]   num_r;
  logic [6:0]    rem_r;
  logic [3:0]    cnt_r;
  logic [7:0]    val_r;
  logic [7:0]    ang_r;
  logic          filled_r;
  logic [22:0]   sprod_r;
  logic [22:0]   cprod_r;
  logic          cneg_r;
  logic          out_vld_r;

  logic [14:0]   mul_a;
  logic [14:0]   mul_b;
  logic [7:0]    rem_sh;
  logic          q_bit;
  logic [13:0]   num_nx;
  logic [7:0]    s_idx;
  logic [7:0]    c_idx;
  logic          ang_hi;
  logic [14:0]   s_mag;
  logic [14:0]   c_mag;
  logic [11:0]   x_pix;
  logic [11:0]   y_pix;
  logic          out_ready;

  assign q_pop     = (st_r == ST_IDLE) && !q_empty;
  assign out_empty = !out_vld_r;
  assign out_ready = !out_vld_r || out_pop;

  assign mul_a  = 15'(cmd_r.prev) * 15'(7'(cmd_r.gap - 7'(k_r)));
  assign mul_b  = 15'(cmd_r.cur) * 15'(k_r);

  // restoring divide by gap, one quotient bit a cycle
  assign rem_sh = {rem_r, num_r[13]};
  assign q_bit  = (rem_sh >= {1'b0, cmd_r.gap});
  assign num_nx = {num_r[12:0], q_bit};

  assign ang_hi = (ang_r > 8'd90);
  assign s_idx  = ang_hi ? 8'(8'(ssc_pkg::ANGLE_TOP) - ang_r) : ang_r;
  assign c_idx  = ang_hi ? 8'(ang_r - 8'd90) : 8'(8'd90 - ang_r);
  assign s_mag  = ssc_pkg::TRIG_ROM[s_idx[6:0]];
  assign c_mag  = ssc_pkg::TRIG_ROM[c_idx[6:0]];

  assign x_pix = 12'(center_x) + 12'(sprod_r[22:14]);
  assign y_pix = cneg_r ? 12'(12'(center_y) + 12'(cprod_r[22:14]))
                        : 12'(12'(center_y) - 12'(cprod_r[22:14]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      if (st_r == ST_EMIT && out_ready) out_vld_r <= 1'b1;
      else if (out_pop && out_vld_r) out_vld_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: begin
          if (!q_empty) begin
            cmd_r    <= q_cmd;
            k_r      <= 6'd1;
            if (q_cmd.fill) begin
              st_r <= ST_MUL;
            end else begin
              ang_r    <= q_cmd.ang;
              val_r    <= q_cmd.cur;
              filled_r <= 1'b0;
              st_r     <= ST_GEO;
            end
          end
        end
        ST_MUL: begin
          num_r <= 14'(mul_a + mul_b);
          rem_r <= '0;
          cnt_r <= '0;
          st_r  <= ST_DIV;
        end
        ST_DIV: begin
          num_r <= num_nx;
          rem_r <= q_bit ? 7'(rem_sh - {1'b0, cmd_r.gap}) : rem_sh[6:0];
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'(ssc_pkg::DIV_STEPS - 1)) begin
            val_r    <= num_nx[7:0];
            ang_r    <= 8'(cmd_r.prev_ang + 8'(k_r));
            filled_r <= 1'b1;
            st_r     <= ST_GEO;
          end
        end
        ST_GEO: begin
          sprod_r <= 23'(cmd_r.depth) * 23'(s_mag);
          cprod_r <= 23'(cmd_r.depth) * 23'(c_mag);
          cneg_r  <= ang_hi;
          st_r    <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_ready) begin
            out_pixel_x      <= x_pix;
            out_pixel_y      <= y_pix;
            out_pixel_color  <= {val_r[7:3], val_r[7:2], val_r[7:3]};
            out_is_filled    <= filled_r;
            out_gap_too_wide <= !filled_r && cmd_r.wide;
            out_last_pixel   <= !filled_r;
            if (filled_r) begin
              if ({1'b0, k_r} == 7'(cmd_r.gap - 7'd1)) begin
                ang_r    <= cmd_r.ang;
                val_r    <= cmd_r.cur;
                filled_r <= 1'b0;
                st_r     <= ST_GEO;
              end else begin
                k_r  <= k_r + 6'd1;
                st_r <= ST_MUL;
              end
            end else begin
              st_r <= ST_IDLE;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_fill_not_wide: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_is_filled) |-> !out_gap_too_wide)
    else $error("fill word flagged as wide gap");

  a_fill_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_is_filled) |-> !out_last_pixel)
    else $error("fill word marked last");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_EMIT && !out_vld_r) |=> out_vld_r)
    else $error("emit did not load output register");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (st_r == ST_MUL || st_r == ST_GEO))
    else $error("command taken without starting work");
`endif

endmodule
`default_nettype wire

[verif/testbench.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sector scan converter testbench
// Pushes echo samples through the queue-style input, predicts every pixel word
// (gap fill, wide-gap flag, last marker) and checks the popped words in order,
// under random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module testbench;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [15:0] color;
    logic        filled;
    logic        wide;
    logic        last;
  } pixel_t;

  class pixel_scoreboard;
    int          sin_tab [0:180];
    int          cos_tab [0:180];
    logic [7:0]  ray_mem [0:255];
    int unsigned ray_ang;
    bit          ray_seen;
    int unsigned cx, cy;
    pixel_t      expected_px[$];
    int          errors, checked, fills, wides;

    function new();
      for (int k = 0; k <= 90; k++) begin
        sin_tab[k] = q14_sine(k);
        sin_tab[180 - k] = sin_tab[k];
      end
      for (int k = 0; k <= 180; k++)
        cos_tab[k] = (k <= 90) ? sin_tab[90 - k] : -sin_tab[k - 90];
      cx = 240;
      cy = 28;
    endfunction

    // Q30 Taylor series of deg*pi/180, rounded to Q1.14
    function int q14_sine(int unsigned deg);
      longint unsigned ang_q30, sq, t;
      longint          acc;
      ang_q30 = (longint'(deg) * 64'd3373259426 + 64'd90) / 64'd180;
      sq = (ang_q30 * ang_q30) >> 30;
      t = ang_q30;
      acc = longint'(ang_q30);
      for (int n = 1; n <= 9; n++) begin
        t = ((t * sq) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc -= longint'(t);
        else acc += longint'(t);
      end
      if (acc < 0) acc = 0;
      return int'((longint'(acc) + 64'd32768) >> 16);
    endfunction

    function int depth_times(int unsigned r, int c);
      int mag;
      mag = (c < 0) ? -c : c;
      mag = (r * mag) >> 14;
      return (c < 0) ? -mag : mag;
    endfunction

    function void add_pixel(int unsigned ang, int unsigned r, int unsigned v,
                            bit filled, bit wide, bit last);
      pixel_t p;
      int     xi, yi;
      logic [7:0] b;
      xi = int'(cx) + depth_times(r, sin_tab[ang]);
      yi = int'(cy) - depth_times(r, cos_tab[ang]);
      b = v[7:0];
      p.x = xi[11:0];
      p.y = yi[11:0];
      p.color = {b[7:3], b[7:2], b[7:3]};
      p.filled = filled;
      p.wide = wide;
      p.last = last;
      expected_px.push_back(p);
    endfunction

    function void note_sample(logic [7:0] ang_in, logic [7:0] r, logic [7:0] cur, logic eor);
      int unsigned ang, gap, v;
      bit          wide;
      ang = (ang_in > 180) ? 180 : ang_in;
      wide = 0;
      if (ray_seen && ang > ray_ang + 1) begin
        gap = ang - ray_ang;
        if (gap - 1 > ssc_pkg::MAX_FILL) begin
          wide = 1;
          wides++;
        end else begin
          for (int k = 1; k < gap; k++) begin
            v = (ray_mem[r] * (gap - k) + cur * k) / gap;
            add_pixel(ray_ang + k, r, v, 1, 0, 0);
            fills++;
          end
        end
      end
      add_pixel(ang, r, cur, 0, wide, 1);
      ray_mem[r] = cur;
      if (eor) begin
        ray_ang = ang;
        ray_seen = 1;
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      checked++;
      if (expected_px.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: pixel word with nothing expected x=%0d y=%0d",
                                   $signed(got.x), $signed(got.y));
        return;
      end
      want = expected_px.pop_front();
      if (got != want) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: word %0d exp x=%h y=%h c=%h f=%b w=%b l=%b got x=%h y=%h c=%h f=%b w=%b l=%b",
                   checked, want.x, want.y, want.color, want.filled, want.wide, want.last,
                   got.x, got.y, got.color, got.filled, got.wide, got.last);
      end
    endfunction

    function int pending();
      return expected_px.size();
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_push = 0;
  logic        in_full;
  logic [7:0]  in_ray_angle = 0;
  logic [7:0]  in_depth_index = 0;
  logic [7:0]  in_echo_value = 0;
  logic        in_ray_end = 0;
  logic        out_empty;
  logic        out_pop = 0;
  logic signed [11:0] out_pixel_x, out_pixel_y;
  logic [15:0] out_pixel_color;
  logic        out_is_filled, out_gap_too_wide, out_last_pixel;
  logic        cfg_we = 0;
  logic        cfg_index = ssc_pkg::REG_CENTER_X;
  logic [9:0]  cfg_data = 0;

  sector_scan_converter dut (.*);

  always #10 clk = ~clk;

  pixel_scoreboard sb = new();

  int  snd_idle_pct = 0;
  int  rcv_idle_pct = 0;
  bit  hold_off_req = 0;
  int  samples_sent = 0;
  int  idle_cycles = 0;

  // stimulus-side shadow, keeps fills away from unwritten history
  bit          gen_seen = 0;
  int unsigned gen_ang = 0;
  bit          gen_written [0:255];

  // receiver: pop decision per cycle, long stall on request
  always @(posedge clk) begin
    pixel_t got;
    if (rst_n && out_pop && !out_empty) begin
      got.x = out_pixel_x;
      got.y = out_pixel_y;
      got.color = out_pixel_color;
      got.filled = out_is_filled;
      got.wide = out_gap_too_wide;
      got.last = out_last_pixel;
      sb.check_pixel(got);
    end
  end

  initial begin
    int hold;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 0;
        out_pop <= 0;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
      end else begin
        out_pop <= rst_n && ($urandom_range(99) >= rcv_idle_pct);
        @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || !rst_n || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("sector_scan_converter: mismatch");
      $finish;
    end
  end

  task automatic send_sample(input int ang_in, input int r, input int cur, input bit eor);
    int unsigned ang;
    ang = (ang_in > 180) ? 180 : ang_in;
    if (gen_seen && ang > gen_ang + 1 && ang - gen_ang - 1 <= ssc_pkg::MAX_FILL &&
        !gen_written[r])
      r = 0;
    gen_written[r] = 1;
    if (eor) begin
      gen_seen = 1;
      gen_ang = ang;
    end
    while ($urandom_range(99) < snd_idle_pct) begin
      in_push <= 0;
      @(posedge clk);
    end
    in_push <= 1;
    in_ray_angle <= ang_in[7:0];
    in_depth_index <= r[7:0];
    in_echo_value <= cur[7:0];
    in_ray_end <= eor;
    do @(posedge clk); while (in_full);
    sb.note_sample(ang_in[7:0], r[7:0], cur[7:0], eor);
    samples_sent++;
  endtask

  task automatic settle();
    in_push <= 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [9:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == ssc_pkg::REG_CENTER_X) sb.cx = val;
    else sb.cy = val;
  endtask

  // well-formed rays mostly, some noise
  task automatic random_sweep(input int count);
    int ang, nsamp, step;
    ang = $urandom_range(180);
    while (count > 0) begin
      if ($urandom_range(9) == 0) begin
        send_sample($urandom_range(255), $urandom_range(255), $urandom_range(255),
                    $urandom_range(1));
        count--;
      end else begin
        case ($urandom_range(9))
          0: step = 0;
          1: step = -$urandom_range(10);
          2: step = $urandom_range(5, 70);
          default: step = $urandom_range(1, 4);
        endcase
        ang += step;
        if (ang < 0 || ang > 185) ang = $urandom_range(20);
        nsamp = $urandom_range(1, 4);
        for (int s = 0; s < nsamp && count > 0; s++) begin
          send_sample(ang, ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(15),
                       $urandom_range(255), s == nsamp - 1);
          count--;
        end
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, fills, backward/repeated angles, wide gaps, saturation
    send_sample(0, 0, 0, 0);
    send_sample(0, 255, 255, 0);
    send_sample(0, 128, 170, 1);
    send_sample(5, 0, 255, 0);
    send_sample(5, 255, 0, 0);
    send_sample(5, 128, 3, 1);
    send_sample(3, 0, 77, 1);
    send_sample(3, 255, 200, 1);
    send_sample(4, 128, 1, 1);
    send_sample(200, 255, 128, 1);
    send_sample(255, 0, 254, 1);
    send_sample(0, 0, 9, 1);
    send_sample(64, 0, 250, 1);
    send_sample(0, 128, 10, 1);
    send_sample(65, 128, 90, 1);
    send_sample(90, 255, 255, 1);
    send_sample(93, 255, 0, 1);
    send_sample(127, 64, 85, 1);
    settle();

    write_reg(ssc_pkg::REG_CENTER_X, 10'd0);
    write_reg(ssc_pkg::REG_CENTER_Y, 10'd0);
    snd_idle_pct = 38;
    rcv_idle_pct = 48;
    random_sweep(90);
    settle();

    write_reg(ssc_pkg::REG_CENTER_X, 10'd1023);
    write_reg(ssc_pkg::REG_CENTER_Y, 10'd1023);
    snd_idle_pct = 48;
    rcv_idle_pct = 38;
    hold_off_req = 1;
    random_sweep(90);
    settle();

    write_reg(ssc_pkg::REG_CENTER_X, 10'($urandom_range(1023)));
    write_reg(ssc_pkg::REG_CENTER_Y, 10'($urandom_range(1023)));
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    random_sweep(100);
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d samples in, %0d pixel words checked (%0d gap fills, %0d wide gaps)",
             samples_sent, sb.checked, sb.fills, sb.wides);
    $display("run: centers at reset, both minimum, both maximum and random; %0d errors",
             sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sector_scan_converter: match");
    end else begin
      $display("sector_scan_converter: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire
